/* design/kcst_pkg.sv */
package kcst_pkg;

    // Fixed field widths.
    localparam int OWNER_BITS  = 32;
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEFAULT   = 64;
    localparam int QTY_BITS_DEFAULT  = 32;
    localparam int ITEM_BITS_DEFAULT = 16;

    // Operation codes carried in the op field.
    typedef enum logic [OP_BITS-1:0] {
        OP_ADD     = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_CONSUME = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_ARG   = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_UNKNOWN   = 3'd5
    } status_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_LOOK,
        S_EXEC
    } state_t;

endpackage

/* design/kcst_req_if.sv */
interface kcst_req_if
    import kcst_pkg::*;
#(
    parameter int QTY_BITS  = QTY_BITS_DEFAULT,
    parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) ();

    logic                        valid;
    logic                        ready;
    logic [OP_BITS-1:0]          op;
    logic [OWNER_BITS-1:0]       owner_id;
    logic [ITEM_BITS-1:0]        item_code;
    logic signed [QTY_BITS-1:0]  amount;
    logic signed [QTY_BITS-1:0]  target_amount;
    logic signed [QTY_BITS-1:0]  capacity_amount;
    logic                        owner_known;

    modport source (
        output valid, op, owner_id, item_code, amount, target_amount,
               capacity_amount, owner_known,
        input  ready
    );

    modport sink (
        input  valid, op, owner_id, item_code, amount, target_amount,
               capacity_amount, owner_known,
        output ready
    );

endinterface

/* design/kcst_rsp_if.sv */
interface kcst_rsp_if
    import kcst_pkg::*;
#(
    parameter int QTY_BITS = QTY_BITS_DEFAULT
) ();

    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status;
    logic [QTY_BITS-2:0]      moved_amount;
    logic [QTY_BITS-2:0]      held_amount;
    logic [QTY_BITS-2:0]      shortfall_amount;
    logic [QTY_BITS-2:0]      room_amount;

    modport source (
        output valid, status, moved_amount, held_amount, shortfall_amount, room_amount,
        input  ready
    );

    modport sink (
        input  valid, status, moved_amount, held_amount, shortfall_amount, room_amount,
        output ready
    );

endinterface

/* design/kcst_key_store.sv */
module kcst_key_store
    import kcst_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEFAULT,
    parameter int ITEM_BITS = ITEM_BITS_DEFAULT,
    parameter int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   lookup,
    input  logic [OWNER_BITS-1:0]  owner,
    input  logic [ITEM_BITS-1:0]   item,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_idx,
    output logic [ENTRIES-1:0]     match_vec,
    output logic [ENTRIES-1:0]     free_first,
    output logic                   full
);

    logic [ENTRIES-1:0]    valid_reg;
    logic [OWNER_BITS-1:0] key_owner_reg [ENTRIES];
    logic [ITEM_BITS-1:0]  key_item_reg [ENTRIES];
    logic [ENTRIES-1:0]    match_reg;
    logic [ENTRIES-1:0]    free_reg;
    logic                  full_reg;
    logic [ENTRIES-1:0]    match_next;
    logic [ENTRIES-1:0]    free_next;

    // Compare the key against every stored key at once.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (key_owner_reg[i] == owner)
                            && (key_item_reg[i] == item);
        end
        // Isolate the lowest clear valid bit.
        free_next = ~valid_reg & (valid_reg + ENTRIES'(1));
    end

    // Valid bits and lookup results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            match_reg <= '0;
            free_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (lookup)
            begin
                match_reg <= match_next;
                free_reg  <= free_next;
                full_reg  <= &valid_reg;
            end
        end
    end

    // Key storage has no reset; it is only compared where valid.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_owner_reg[wr_idx] <= owner;
            key_item_reg[wr_idx]  <= item;
        end
    end

    assign match_vec  = match_reg;
    assign free_first = free_reg;
    assign full       = full_reg;

endmodule

/* design/keyed_capacity_stock_table.sv */
// A request word is captured, then passes in turn through the key compare, the index encode
// with entry memory read, and the read-modify-write of the entry memory into the output register.
// No new request word is taken until the one before has been written to the output register.
// A request is taken while an earlier result still waits at the output register.
// Reset clears the valid bits and the control state; no clearing pass is needed.
module keyed_capacity_stock_table
    import kcst_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEFAULT,
    parameter int QTY_BITS  = QTY_BITS_DEFAULT,
    parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    kcst_req_if.sink   req,
    kcst_rsp_if.source rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int W1    = QTY_BITS + 1;
    localparam int OW    = QTY_BITS - 1;

    state_t state_reg, state_next;

    // Captured request.
    op_t                       op_reg;
    logic [OWNER_BITS-1:0]     owner_reg;
    logic [ITEM_BITS-1:0]      item_reg;
    logic signed [QTY_BITS-1:0] amount_reg;
    logic signed [QTY_BITS-1:0] target_reg;
    logic signed [QTY_BITS-1:0] cap_reg;
    logic                      known_reg;

    // Lookup results.
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] free_first;
    logic               full;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               found_reg;
    logic               full_reg;

    // Entry memory: target, capacity and quantity side by side.
    logic [3*QTY_BITS-1:0] entry_mem [ENTRIES];
    logic [3*QTY_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [3*QTY_BITS-1:0] mem_wdata;

    // Output register.
    logic                   rsp_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [OW-1:0]          moved_reg;
    logic [OW-1:0]          held_reg;
    logic [OW-1:0]          short_reg;
    logic [OW-1:0]          room_reg;

    // Execute-stage values.
    logic                   out_free;
    logic                   fire;
    logic                   key_wr;
    status_t                status_c;
    logic signed [W1-1:0]   a_w, t_w, c_w, q_w, rd_t, rd_c, rd_q;
    logic signed [W1-1:0]   room_cur, moved_w, eff_q, short_w, room_w;
    logic                   bad_add;
    logic                   add_ok;
    logic                   present;
    logic [OW-1:0]          moved_o, held_o, short_o, room_o;

    kcst_key_store #(
        .ENTRIES   (ENTRIES),
        .ITEM_BITS (ITEM_BITS),
        .IDX_W     (IDX_W)
    ) u_key_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup     (state_reg == S_MATCH),
        .owner      (owner_reg),
        .item       (item_reg),
        .wr_en      (key_wr),
        .wr_idx     (free_idx_reg),
        .match_vec  (match_vec),
        .free_first (free_first),
        .full       (full)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign fire      = (state_reg == S_EXEC) && out_free;

    // Encode the match and free vectors; each holds at most one set bit.
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (free_first[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH: state_next = S_LOOK;
            S_LOOK:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, lookup registers and output payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= op_t'(req.op);
            owner_reg  <= req.owner_id;
            item_reg   <= req.item_code;
            amount_reg <= req.amount;
            target_reg <= req.target_amount;
            cap_reg    <= req.capacity_amount;
            known_reg  <= req.owner_known;
        end
        if (state_reg == S_LOOK)
        begin
            match_idx_reg <= match_idx;
            free_idx_reg  <= free_idx;
            found_reg     <= |match_vec;
            full_reg      <= full;
        end
        if (fire)
        begin
            status_reg <= status_c;
            moved_reg  <= moved_o;
            held_reg   <= held_o;
            short_reg  <= short_o;
            room_reg   <= room_o;
        end
    end

    // Entry memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_LOOK)
        begin
            rdata_reg <= entry_mem[match_idx];
        end
    end

    // Execute: checks, amount moved and the entry as it stands afterward.
    always_comb
    begin
        a_w  = {amount_reg[QTY_BITS-1], amount_reg};
        t_w  = {target_reg[QTY_BITS-1], target_reg};
        c_w  = {cap_reg[QTY_BITS-1], cap_reg};
        rd_t = {rdata_reg[3*QTY_BITS-1], rdata_reg[3*QTY_BITS-1:2*QTY_BITS]};
        rd_c = {rdata_reg[2*QTY_BITS-1], rdata_reg[2*QTY_BITS-1:QTY_BITS]};
        rd_q = {rdata_reg[QTY_BITS-1], rdata_reg[QTY_BITS-1:0]};

        bad_add = (owner_reg == '0) || (item_reg == '0) || (t_w < 0) || (c_w <= 0)
                  || (t_w > c_w) || (a_w < 0) || (a_w > c_w);

        room_cur = rd_c - rd_q;
        if (room_cur < 0)
        begin
            room_cur = '0;
        end

        status_c = STAT_OK;
        moved_w  = '0;
        add_ok   = 1'b0;
        eff_q    = rd_q;
        case (op_reg)
            OP_ADD:
            begin
                if (bad_add)
                begin
                    status_c = STAT_BAD_ARG;
                end
                else if (found_reg)
                begin
                    status_c = STAT_DUPLICATE;
                end
                else if (!known_reg)
                begin
                    status_c = STAT_UNKNOWN;
                end
                else if (full_reg)
                begin
                    status_c = STAT_FULL;
                end
                else
                begin
                    add_ok = 1'b1;
                end
            end
            OP_RECEIVE:
            begin
                if (a_w <= 0)
                begin
                    status_c = STAT_BAD_ARG;
                end
                else if (!found_reg)
                begin
                    status_c = STAT_NOT_FOUND;
                end
                else
                begin
                    moved_w = (a_w < room_cur) ? a_w : room_cur;
                    eff_q   = rd_q + moved_w;
                end
            end
            OP_CONSUME:
            begin
                if (a_w <= 0)
                begin
                    status_c = STAT_BAD_ARG;
                end
                else if (!found_reg)
                begin
                    status_c = STAT_NOT_FOUND;
                end
                else
                begin
                    moved_w = (a_w < rd_q) ? a_w : rd_q;
                    eff_q   = rd_q - moved_w;
                end
            end
            OP_QUERY:
            begin
                if (!found_reg)
                begin
                    status_c = STAT_NOT_FOUND;
                end
            end
            default: status_c = STAT_OK;
        endcase

        // A new entry reports its own fields; otherwise the stored entry does.
        present = add_ok || found_reg;
        if (add_ok)
        begin
            q_w = a_w;
            short_w = t_w - a_w;
            room_w  = c_w - a_w;
        end
        else
        begin
            q_w = eff_q;
            short_w = rd_t - eff_q;
            room_w  = rd_c - eff_q;
        end
        if (short_w < 0)
        begin
            short_w = '0;
        end
        if (room_w < 0)
        begin
            room_w = '0;
        end

        moved_o = moved_w[OW-1:0];
        held_o  = present ? q_w[OW-1:0] : '0;
        short_o = present ? short_w[OW-1:0] : '0;
        room_o  = present ? room_w[OW-1:0] : '0;

        // Write back a new entry or the updated quantity.
        key_wr    = fire && add_ok;
        mem_we    = fire && (add_ok || (moved_w != 0));
        mem_waddr = add_ok ? free_idx_reg : match_idx_reg;
        if (add_ok)
        begin
            mem_wdata = {target_reg, cap_reg, amount_reg};
        end
        else
        begin
            mem_wdata = {rdata_reg[3*QTY_BITS-1:QTY_BITS], eff_q[QTY_BITS-1:0]};
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.moved_amount     = moved_reg;
    assign rsp.held_amount      = held_reg;
    assign rsp.shortfall_amount = short_reg;
    assign rsp.room_amount      = room_reg;

endmodule
